// ----- rtl/lirr_pkg.sv -----
// Shared types and constants for the linear interpolation resampler with rate ramp.
// No dependencies; imported by the top level and the port checker.
`default_nettype none
package lirr_pkg;

  localparam int SAMPLE_W = 24;
  localparam int RATE_W   = 24;
  localparam int STEP_W   = 25;
  localparam int POS_W    = 25;
  localparam int FRAC_W   = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int CFG_W    = 25;
  localparam int MAX_OUTPUTS_PER_INPUT = 64;
  localparam int CNT_W    = $clog2(MAX_OUTPUTS_PER_INPUT);

  localparam logic [POS_W-1:0]  ONE_Q16    = POS_W'(65536);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);
  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(MAX_OUTPUTS_PER_INPUT - 1);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  typedef enum logic [1:0] {
    REG_RATE_START  = 2'd0,
    REG_RATE_TARGET = 2'd1,
    REG_RATE_STEP   = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL_L = 4'b0010,
    S_MUL_R = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/linear_interp_resampler_rate_ramp_unit.sv -----
// Stereo linear interpolation resampler with a per-output rate ramp.
// Each output is computed in states S_MUL_L and S_MUL_R and registered from S_EMIT once
// the output register is free (one shared 25x17 multiplier, left then right).
// A frame's outputs (at most 64) all go out before the next frame; one with none leaves it idle.
// Input ready only while the sequencer idles; the output register decouples the sink.
// Reset (rst, synchronous): prev frame 0, position 1.0, rate 1.0, step 0, target 1.0.
`default_nettype none
module linear_interp_resampler_rate_ramp_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire lirr_pkg::in_item_t          in_data,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      lirr_pkg::out_item_t         out_data,
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [lirr_pkg::CFG_W-1:0]  cfg_data
);
  import lirr_pkg::*;

  state_t state;

  logic signed [SAMPLE_W-1:0] prev_left, prev_right;
  logic signed [SAMPLE_W-1:0] cur_left, cur_right;
  logic signed [DIFF_W-1:0]   diff_left, diff_right;
  logic [POS_W-1:0]           read_position;
  logic [RATE_W-1:0]          current_rate;
  logic [RATE_W-1:0]          rate_target;
  logic signed [STEP_W-1:0]   rate_step;
  logic [CNT_W-1:0]           count;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] lerp_left;

  logic                       in_fire;
  logic                       out_free;
  logic [POS_W-1:0]           pos_adj;
  logic [POS_W-1:0]           pos_next;
  logic                       last;
  logic signed [DIFF_W-1:0]   mul_a;
  logic signed [FRAC_W:0]     mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]          round_sum;
  logic signed [DIFF_W-1:0]   quot;
  logic signed [DIFF_W:0]     lerp_sum;
  logic signed [RATE_W+1:0]   rate_sum;
  logic signed [RATE_W+1:0]   target_ext;
  logic [RATE_W-1:0]          rate_next;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign pos_adj = ((read_position < ONE_Q16) ? ONE_Q16 : read_position) - ONE_Q16;

  // shared multiplier: diff * frac, frac zero-extended
  assign mul_a = (state == S_MUL_R) ? diff_right : diff_left;
  assign mul_b = $signed({1'b0, read_position[FRAC_W-1:0]});
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign round_sum = $unsigned(prod) + ROUND_HALF;
  assign quot      = $signed(round_sum[FRAC_W +: DIFF_W]);

  always_comb begin
    if (state == S_MUL_R) begin
      lerp_sum = (DIFF_W+1)'(prev_left) + (DIFF_W+1)'(quot);
    end else begin
      lerp_sum = (DIFF_W+1)'(prev_right) + (DIFF_W+1)'(quot);
    end
  end

  assign pos_next = read_position + POS_W'(current_rate);
  assign last     = (pos_next >= ONE_Q16) || (count == CNT_LAST);

  assign rate_sum   = $signed({2'b00, current_rate}) + (RATE_W+2)'(rate_step);
  assign target_ext = $signed({2'b00, rate_target});

  always_comb begin
    rate_next = rate_sum[RATE_W-1:0];
    if ((rate_step > 0 && rate_sum > target_ext) ||
        (rate_step < 0 && rate_sum < target_ext)) begin
      rate_next = rate_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      prev_left     <= '0;
      prev_right    <= '0;
      read_position <= ONE_Q16;
      current_rate  <= RATE_RESET;
      rate_target   <= RATE_RESET;
      rate_step     <= '0;
      count         <= '0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur_left   <= in_data.sample_left;
            cur_right  <= in_data.sample_right;
            diff_left  <= DIFF_W'(in_data.sample_left) - DIFF_W'(prev_left);
            diff_right <= DIFF_W'(in_data.sample_right) - DIFF_W'(prev_right);
            count      <= '0;
            if (pos_adj < ONE_Q16) begin
              read_position <= pos_adj;
              state         <= S_MUL_L;
            end else begin
              read_position <= pos_adj;
              prev_left     <= in_data.sample_left;
              prev_right    <= in_data.sample_right;
            end
          end
        end
        S_MUL_L: begin
          prod  <= mul_p;
          state <= S_MUL_R;
        end
        S_MUL_R: begin
          lerp_left <= lerp_sum[SAMPLE_W-1:0];
          prod      <= mul_p;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data.out_left    <= lerp_left;
            out_data.out_right   <= lerp_sum[SAMPLE_W-1:0];
            out_data.last_of_run <= last;
            current_rate         <= rate_next;
            count                <= count + CNT_W'(1);
            if (last) begin
              read_position <= (pos_next < ONE_Q16) ? ONE_Q16 : pos_next;
              prev_left     <= cur_left;
              prev_right    <= cur_right;
              state         <= S_IDLE;
            end else begin
              read_position <= pos_next;
              state         <= S_MUL_L;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RATE_START:  current_rate <= cfg_data[RATE_W-1:0];
          REG_RATE_TARGET: rate_target  <= cfg_data[RATE_W-1:0];
          REG_RATE_STEP:   rate_step    <= $signed(cfg_data[STEP_W-1:0]);
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lirr_checker.sv -----
// Port-level checker for linear_interp_resampler_rate_ramp_unit, bound to the top level.
// Depends on lirr_pkg for the payload types.
`default_nettype none
module lirr_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lirr_pkg::out_item_t out_data
);
  import lirr_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // mid-run output pending means the sequencer is busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("input ready while a run is unfinished");

  // reset leaves the block idle and empty
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind linear_interp_resampler_rate_ramp_unit lirr_checker u_lirr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- dv/linear_interp_resampler_rate_ramp_unit_monitor.sv -----
`timescale 1ns / 100ps
// Port monitor for the rate-ramp resampler: tracks register writes and input
// transactions, predicts the interpolated output frames and compares each output
// transaction with them. Depends on lirr_pkg.
module linear_interp_resampler_rate_ramp_unit_monitor
  import lirr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   outputs_owed,
  output int                   mismatches
);

  logic [RATE_W-1:0]          start_rate;
  logic [RATE_W-1:0]          goal_rate;
  logic signed [STEP_W-1:0]   ramp_incr;
  logic [RATE_W-1:0]          live_rate;
  logic [POS_W-1:0]           read_pos;
  logic signed [SAMPLE_W-1:0] last_left;
  logic signed [SAMPLE_W-1:0] last_right;
  out_item_t                  owed_frames[$];
  int                         errs;

  initial begin
    outputs_owed = 0;
    mismatches   = 0;
    errs         = 0;
  end

  function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] a,
                                                        input logic signed [SAMPLE_W-1:0] b,
                                                        input logic [FRAC_W-1:0] frac);
    longint prod;
    longint mixed;
    prod  = (longint'(b) - longint'(a)) * longint'({1'b0, frac});
    mixed = longint'(a) + ((prod + 32768) >>> FRAC_W);
    return mixed[SAMPLE_W-1:0];
  endfunction

  task automatic advance_rate();
    longint nr;
    nr = longint'(live_rate) + longint'(ramp_incr);
    if ((ramp_incr > 0 && nr > longint'(goal_rate)) ||
        (ramp_incr < 0 && nr < longint'(goal_rate)))
      nr = longint'(goal_rate);
    live_rate = nr[RATE_W-1:0];
  endtask

  task automatic predict_outputs(input in_item_t frame);
    int        n;
    out_item_t o;
    n = 0;
    if (read_pos < ONE_Q16) read_pos = ONE_Q16;
    read_pos = read_pos - ONE_Q16;
    while (read_pos < ONE_Q16 && n < MAX_OUTPUTS_PER_INPUT) begin
      o.out_left    = blend(last_left, frame.sample_left, read_pos[FRAC_W-1:0]);
      o.out_right   = blend(last_right, frame.sample_right, read_pos[FRAC_W-1:0]);
      o.last_of_run = 1'b0;
      owed_frames.push_back(o);
      n++;
      read_pos = read_pos + POS_W'(live_rate);
      advance_rate();
    end
    if (read_pos < ONE_Q16) read_pos = ONE_Q16;
    if (n > 0) begin
      o = owed_frames.pop_back();
      o.last_of_run = 1'b1;
      owed_frames.push_back(o);
    end
    last_left  = frame.sample_left;
    last_right = frame.sample_right;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      start_rate = RATE_RESET;
      goal_rate  = RATE_RESET;
      ramp_incr  = '0;
      live_rate  = RATE_RESET;
      read_pos   = ONE_Q16;
      last_left  = '0;
      last_right = '0;
      owed_frames.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RATE_START: begin
            start_rate = cfg_data[RATE_W-1:0];
            live_rate  = start_rate;
          end
          REG_RATE_TARGET: goal_rate = cfg_data[RATE_W-1:0];
          REG_RATE_STEP:   ramp_incr = signed'(cfg_data[STEP_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_outputs(in_data);
      if (out_valid && out_ready) begin
        if (owed_frames.size() == 0) begin
          errs++;
          $display("%0t unexpected output: expected none, got %0d / %0d last %0b",
                   $time, out_data.out_left, out_data.out_right, out_data.last_of_run);
        end else begin
          want = owed_frames.pop_front();
          if (out_data.out_left !== want.out_left) begin
            errs++;
            $display("%0t out_left: expected %0d, got %0d",
                     $time, want.out_left, out_data.out_left);
          end
          if (out_data.out_right !== want.out_right) begin
            errs++;
            $display("%0t out_right: expected %0d, got %0d",
                     $time, want.out_right, out_data.out_right);
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            errs++;
            $display("%0t last_of_run: expected %0b, got %0b",
                     $time, want.last_of_run, out_data.last_of_run);
          end
        end
      end
    end
    outputs_owed <= owed_frames.size();
    mismatches   <= errs;
  end

endmodule

// ----- dv/linear_interp_resampler_rate_ramp_unit_test.sv -----
`timescale 1ns / 100ps
// Top of the resampler testbench: clock, reset, register programming, frame and
// sink traffic, and the verdict. Depends on lirr_pkg, the block and its port monitor.
module linear_interp_resampler_rate_ramp_unit_test;
  import lirr_pkg::*;

  localparam logic [1:0]                 REG_SPARE     = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI     = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO     = 24'sh800000;
  localparam logic [RATE_W-1:0]          RATE_MAX      = 24'hFFFFFF;
  localparam int                         STEP_EXTREME  = 16777215;
  localparam int                         RANDOM_FRAMES = 160;
  localparam int                         FAST_FRAMES   = 30;
  localparam int                         SINK_HOLD     = 400;
  localparam int                         SETTLE        = 8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = REG_RATE_START;
  logic [CFG_W-1:0] cfg_data = '0;
  int               outputs_owed;
  int               mismatches;
  bit               hold_sink = 1'b0;
  bit               sink_eager = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  linear_interp_resampler_rate_ramp_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  linear_interp_resampler_rate_ramp_unit_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outputs_owed(outputs_owed), .mismatches(mismatches)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_HI;
      1:       return SAMPLE_LO;
      2:       return 24'(int'($urandom_range(0, 512)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_frame();
    in_item_t f;
    f.sample_left  = pick_sample();
    f.sample_right = pick_sample();
    return f;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return 24'($urandom_range(1024, 8192));
      1:       return 24'(65536);
      2:       return 24'($urandom_range(98304, 200000));
      default: return 24'($urandom_range(12000, 98304));
    endcase
  endfunction

  function automatic logic signed [STEP_W-1:0] pick_step();
    int mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5, 6, 7: mag = $urandom_range(1, 2048);
      8:          mag = $urandom_range(2049, 65536);
      default:    mag = STEP_EXTREME;
    endcase
    return $urandom_range(0, 1) ? 25'(-mag) : 25'(mag);
  endfunction

  // back-to-back register writes; write enable is raised once and lowered once
  task automatic program_rates(input logic [RATE_W-1:0] start_q,
                               input logic [RATE_W-1:0] target_q,
                               input logic signed [STEP_W-1:0] step_q,
                               input bit poke_spare);
    cfg_write <= 1'b1;
    cfg_index <= REG_RATE_TARGET;
    cfg_data  <= {1'b0, target_q};
    @(posedge clk);
    cfg_index <= REG_RATE_STEP;
    cfg_data  <= step_q;
    @(posedge clk);
    cfg_index <= REG_RATE_START;
    cfg_data  <= {1'b0, start_q};
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= '1;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_frame(input in_item_t f, input int gap);
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outputs_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // output side: random stalls, eager stretches, and one long hold-off
  initial begin : sink
    int stall;
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat (sink_eager ? 1 : $urandom_range(1, 12)) @(posedge clk);
        stall = sink_eager ? 0 : pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #(200_000_000);
    $display("linear_interp_resampler_rate_ramp_unit_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int  random_sent;
    int  phase;
    int  phase_len;
    bit  sender_quiet;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset rates (unit rate, no ramp), full-scale swings
    send_frame(in_item_t'{SAMPLE_HI, SAMPLE_LO}, pick_gap());
    send_frame(in_item_t'{SAMPLE_LO, SAMPLE_HI}, pick_gap());
    send_frame(in_item_t'{24'sd0, 24'sd0}, pick_gap());
    wait_idle();

    // slowest legal rate: 64 outputs per frame across the whole swing
    program_rates(24'd1024, 24'd1024, '0, 1'b0);
    send_frame(in_item_t'{SAMPLE_HI, SAMPLE_LO}, pick_gap());
    send_frame(in_item_t'{SAMPLE_LO, SAMPLE_HI}, pick_gap());
    wait_idle();

    // upward ramp toward a target these frames do not reach, spare index written and ignored
    program_rates(24'd40000, 24'd70000, 25'sd300, 1'b1);
    send_frame(in_item_t'{SAMPLE_HI, SAMPLE_LO}, pick_gap());
    send_frame(in_item_t'{SAMPLE_LO, SAMPLE_HI}, pick_gap());
    send_frame(in_item_t'{SAMPLE_HI, SAMPLE_HI}, pick_gap());
    send_frame(in_item_t'{SAMPLE_LO, SAMPLE_LO}, pick_gap());
    wait_idle();

    // large negative step (-16777215) snaps straight to target
    program_rates(24'd120000, 24'd1024, 25'(-STEP_EXTREME), 1'b0);
    send_frame(random_frame(), pick_gap());
    send_frame(random_frame(), pick_gap());
    wait_idle();

    // most positive step snaps to target
    program_rates(24'd1024, 24'd2048, 25'(STEP_EXTREME), 1'b0);
    send_frame(random_frame(), pick_gap());
    send_frame(random_frame(), pick_gap());
    wait_idle();

    // zero and sub-minimum rates: output cap ends the run, position forced to 1.0
    program_rates(24'd0, 24'd0, '0, 1'b0);
    send_frame(random_frame(), pick_gap());
    wait_idle();
    program_rates(24'd512, 24'd512, '0, 1'b0);
    send_frame(random_frame(), pick_gap());
    send_frame(random_frame(), pick_gap());
    wait_idle();

    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_FRAMES) begin
      if (phase == 1) begin
        // sink holds off while frames keep coming, so the block backs up
        program_rates(24'd30000, 24'd30000, '0, 1'b0);
        sink_eager   = 1'b0;
        hold_sink    = 1'b1;
        sender_quiet = 1'b1;
        phase_len    = 24;
      end else begin
        program_rates(pick_rate(), pick_rate(), pick_step(), 1'b0);
        sink_eager   = ($urandom_range(0, 4) == 0);
        sender_quiet = ($urandom_range(0, 4) == 0);
        phase_len    = $urandom_range(8, 24);
      end
      for (int k = 0; k < phase_len; k++) begin
        send_frame(random_frame(), sender_quiet ? 0 : pick_gap());
        random_sent++;
      end
      wait_idle();
      phase++;
    end

    // highest rate: one output, then a run of frames with no output
    sink_eager = 1'b0;
    program_rates(RATE_MAX, RATE_MAX, '0, 1'b0);
    for (int k = 0; k < FAST_FRAMES; k++)
      send_frame(random_frame(), ($urandom_range(0, 9) == 0) ? pick_gap() : 0);
    wait_idle();

    if (mismatches == 0 && outputs_owed == 0)
      $display("linear_interp_resampler_rate_ramp_unit_test: done, clean");
    else
      $display("linear_interp_resampler_rate_ramp_unit_test: done, errors");
    $finish;
  end

endmodule
